// File: src/i2cmrr_pkg.sv
// Shared types and constants for the I2C master register read block.
`default_nettype none

package i2cmrr_pkg;

    // Phase map of one transaction (128 phases)
    localparam logic [6:0] PH_W1   = 7'd3;    // device address, write
    localparam logic [6:0] PH_W2   = 7'd30;   // register address
    localparam logic [6:0] PH_RS   = 7'd57;   // repeated start
    localparam logic [6:0] PH_W3   = 7'd60;   // device address, read
    localparam logic [6:0] PH_R1   = 7'd87;   // first data byte, ACK
    localparam logic [6:0] PH_R2   = 7'd106;  // second data byte, NACK
    localparam logic [6:0] PH_STOP = 7'd125;  // stop
    localparam logic [6:0] PH_LAST = 7'd127;

    // Written byte: 8 bits of 3 phases, then ack release, ack sample, SCL low
    localparam logic [4:0] WR_BITS_END = 5'd24;
    localparam logic [4:0] WR_ACK_REL  = 5'd24;
    localparam logic [4:0] WR_ACK_SMP  = 5'd25;
    // Read byte: 8 bits of 2 phases, then ack drive, SCL high, SCL low
    localparam logic [4:0] RD_BITS_END = 5'd16;
    localparam logic [4:0] RD_LAST_BIT = 5'd14;
    localparam logic [4:0] RD_ACK_DRV  = 5'd16;
    localparam logic [4:0] RD_ACK_CLK  = 5'd17;

    // Sub-phase of one written bit
    localparam logic [1:0] SUB_DRIVE = 2'd0;
    localparam logic [1:0] SUB_RISE  = 2'd1;
    localparam logic [1:0] SUB_FALL  = 2'd2;

    localparam logic [6:0] DEV_ADDR_RST = 7'h0A;
    localparam logic       RW_READ      = 1'b1;
    localparam logic       RW_WRITE     = 1'b0;

    typedef struct packed {
        logic       action;
        logic [7:0] target_reg;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        nack_seen;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/i2cmrr_in_if.sv
// Input channel: one phase tick item with optional read request.
`default_nettype none

interface i2cmrr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] target_reg;
    logic       sda_in;

    modport source (output valid, action, target_reg, sda_in, input ready);
    modport sink   (input valid, action, target_reg, sda_in, output ready);
endinterface

`default_nettype wire

// File: src/i2cmrr_out_if.sv
// Output channel: line levels and transaction status for each tick.
`default_nettype none

interface i2cmrr_out_if;
    logic        valid;
    logic        ready;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        nack_seen;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    nack_seen, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    nack_seen, output ready);
endinterface

`default_nettype wire

// File: src/i2c_master_register_read_unit.sv
// Top level: input register, phase sequencer and output register.
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid/ready   | action, target_reg, sda_in
//  o_out   | out | valid/ready   | scl_out, sda_out, busy_res, done_res, read_data, nack_seen
//  cfg     | in  | i_cfg_we      | i_cfg_data (device_address)
//
// One item per cycle while the output is not stalled; an item is held in the input register and
// its result is then offered from the output register once it leaves the input register.
// The sequencer state advances when an item moves from the input register into
// the output register, so a stalled output holds the bus phase in place.
// Reset is synchronous; in.ready is low while reset is asserted.
// The device address resets to 0x0A and is used live at each address byte.
`default_nettype none

module i2c_master_register_read_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2cmrr_in_if.sink   i_in,
    i2cmrr_out_if.source o_out,
    input  wire logic   i_cfg_we,
    input  wire logic [6:0] i_cfg_data
);

    logic                   r_in_valid;
    i2cmrr_pkg::t_in_item   r_in_item;
    logic                   r_out_valid;
    i2cmrr_pkg::t_out_item  r_out_item;
    logic [6:0]             r_dev_addr;

    logic                   step;
    i2cmrr_pkg::t_out_item  seq_res;

    // Stage advance and handshakes
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || step);

    // Device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= i2cmrr_pkg::DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.action     <= i_in.action;
            r_in_item.target_reg <= i_in.target_reg;
            r_in_item.sda_in     <= i_in.sda_in;
        end
    end

    i2cmrr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in_item),
        .i_dev_addr (r_dev_addr),
        .o_res      (seq_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= seq_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_out_item.scl_out;
    assign o_out.sda_out   = r_out_item.sda_out;
    assign o_out.busy_res  = r_out_item.busy_res;
    assign o_out.done_res  = r_out_item.done_res;
    assign o_out.read_data = r_out_item.read_data;
    assign o_out.nack_seen = r_out_item.nack_seen;

endmodule

`default_nettype wire

// File: src/i2cmrr_seq.sv
// Phase sequencer: transaction state and the per-tick line and result logic.
`default_nettype none

module i2cmrr_seq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire i2cmrr_pkg::t_in_item   i_item,
    input  wire logic [6:0]             i_dev_addr,
    output i2cmrr_pkg::t_out_item       o_res
);

    typedef enum logic [1:0] {
        SEG_START,
        SEG_WRITE,
        SEG_READ,
        SEG_STOP
    } t_seg;

    logic        r_active;
    logic [6:0]  r_phase;
    logic [1:0]  r_sub;      // phase mod 3, aligned with written bits
    logic        r_scl;
    logic        r_sda;
    logic [7:0]  r_latched;
    logic [7:0]  r_shift;
    logic [15:0] r_word;
    logic        r_nack;

    logic        n_active;
    logic [6:0]  n_phase;
    logic [1:0]  n_sub;
    logic        n_scl;
    logic        n_sda;
    logic [7:0]  n_latched;
    logic [7:0]  n_shift;
    logic [15:0] n_word;
    logic        n_nack;

    logic        start;
    logic        act;
    logic        done;
    logic [6:0]  p;
    logic [1:0]  sub;
    logic [7:0]  shift_b;
    t_seg        seg;
    logic [6:0]  base;
    logic [6:0]  off_full;
    logic [4:0]  off;
    logic [7:0]  wr_byte;
    logic        rd_upper;

    // Segment decode and one phase of bus activity
    always_comb begin
        start    = !r_active && i_item.action;
        act      = r_active || start;
        p        = start ? 7'd0 : r_phase;
        sub      = start ? i2cmrr_pkg::SUB_DRIVE : r_sub;
        shift_b  = start ? 8'd0 : r_shift;
        n_latched = start ? i_item.target_reg : r_latched;
        n_word   = start ? 16'd0 : r_word;
        n_nack   = start ? 1'b0 : r_nack;
        n_shift  = shift_b;
        n_scl    = r_scl;
        n_sda    = r_sda;
        rd_upper = 1'b1;
        wr_byte  = {i_dev_addr, i2cmrr_pkg::RW_WRITE};

        if (p < i2cmrr_pkg::PH_W1) begin
            seg  = SEG_START;
            base = 7'd0;
        end else if (p < i2cmrr_pkg::PH_W2) begin
            seg  = SEG_WRITE;
            base = i2cmrr_pkg::PH_W1;
        end else if (p < i2cmrr_pkg::PH_RS) begin
            seg     = SEG_WRITE;
            base    = i2cmrr_pkg::PH_W2;
            wr_byte = n_latched;
        end else if (p < i2cmrr_pkg::PH_W3) begin
            seg  = SEG_START;
            base = i2cmrr_pkg::PH_RS;
        end else if (p < i2cmrr_pkg::PH_R1) begin
            seg     = SEG_WRITE;
            base    = i2cmrr_pkg::PH_W3;
            wr_byte = {i_dev_addr, i2cmrr_pkg::RW_READ};
        end else if (p < i2cmrr_pkg::PH_R2) begin
            seg  = SEG_READ;
            base = i2cmrr_pkg::PH_R1;
        end else if (p < i2cmrr_pkg::PH_STOP) begin
            seg      = SEG_READ;
            base     = i2cmrr_pkg::PH_R2;
            rd_upper = 1'b0;
        end else begin
            seg  = SEG_STOP;
            base = i2cmrr_pkg::PH_STOP;
        end

        off_full = p - base;
        off      = off_full[4:0];

        if (act) begin
            case (seg)
                SEG_START: begin
                    if (off == 5'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (off == 5'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                SEG_WRITE: begin
                    if (off < i2cmrr_pkg::WR_BITS_END) begin
                        case (sub)
                            i2cmrr_pkg::SUB_DRIVE: begin
                                if (off == 5'd0) begin
                                    n_shift = wr_byte;
                                end
                                n_sda = n_shift[7];
                            end
                            i2cmrr_pkg::SUB_RISE: begin
                                n_scl = 1'b1;
                            end
                            default: begin
                                n_scl   = 1'b0;
                                n_shift = {shift_b[6:0], 1'b0};
                            end
                        endcase
                    end else if (off == i2cmrr_pkg::WR_ACK_REL) begin
                        n_sda = 1'b1;
                    end else if (off == i2cmrr_pkg::WR_ACK_SMP) begin
                        n_scl = 1'b1;
                        if (i_item.sda_in) begin
                            n_nack = 1'b1;
                        end
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                SEG_READ: begin
                    if (off < i2cmrr_pkg::RD_BITS_END) begin
                        if (!off[0]) begin
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                            n_shift = {shift_b[6:0], i_item.sda_in};
                            if (off == i2cmrr_pkg::RD_LAST_BIT) begin
                                if (rd_upper) begin
                                    n_word = {n_shift, n_word[7:0]};
                                end else begin
                                    n_word = {n_word[15:8], n_shift};
                                end
                            end
                        end else begin
                            n_scl = 1'b0;
                        end
                    end else if (off == i2cmrr_pkg::RD_ACK_DRV) begin
                        // ACK on the first byte, NACK on the second
                        n_sda = !rd_upper;
                    end else if (off == i2cmrr_pkg::RD_ACK_CLK) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                default: begin
                    if (off == 5'd0) begin
                        n_sda = 1'b0;
                    end else if (off == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
            endcase
        end

        // Phase advance
        done = act && (p == i2cmrr_pkg::PH_LAST);
        if (!act) begin
            n_active = 1'b0;
            n_phase  = r_phase;
            n_sub    = r_sub;
        end else if (done) begin
            n_active = 1'b0;
            n_phase  = 7'd0;
            n_sub    = i2cmrr_pkg::SUB_DRIVE;
        end else begin
            n_active = 1'b1;
            n_phase  = p + 7'd1;
            n_sub    = (sub == i2cmrr_pkg::SUB_FALL) ? i2cmrr_pkg::SUB_DRIVE : sub + 2'd1;
        end

        o_res.scl_out   = n_scl;
        o_res.sda_out   = n_sda;
        o_res.busy_res  = act;
        o_res.done_res  = done;
        o_res.read_data = done ? n_word : 16'd0;
        o_res.nack_seen = done && n_nack;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= 7'd0;
            r_sub    <= i2cmrr_pkg::SUB_DRIVE;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
        end else if (i_step) begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_sub    <= n_sub;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
        end
    end

    // Data state, reloaded at each transaction start
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_latched <= n_latched;
            r_shift   <= n_shift;
            r_word    <= n_word;
            r_nack    <= n_nack;
        end
    end

endmodule

`default_nettype wire

// File: src/i2cmrr_chk.sv
// Port-level checker for the register read block, bound to the top level.
`default_nettype none

module i2cmrr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_scl_out,
    input wire logic        i_sda_out,
    input wire logic        i_busy_res,
    input wire logic        i_done_res,
    input wire logic [15:0] i_read_data,
    input wire logic        i_nack_seen
);

    // A finished transaction is always reported as busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> i_busy_res)
        else $error("done without busy");

    // Read word and nack flag stay zero except on the final phase
    a_data_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res |-> (i_read_data == 16'd0) && !i_nack_seen)
        else $error("result data outside final phase");

    // A new result follows an item accepted into the input register
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without accepted item");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_valid && !i_out_ready && i_rst_n) |->
            i_out_valid && $stable(i_read_data) && $stable(i_done_res)
            && $stable(i_scl_out) && $stable(i_sda_out))
        else $error("stalled result changed");

endmodule

bind i2c_master_register_read_unit i2cmrr_chk u_i2cmrr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_scl_out   (o_out.scl_out),
    .i_sda_out   (o_out.sda_out),
    .i_busy_res  (o_out.busy_res),
    .i_done_res  (o_out.done_res),
    .i_read_data (o_out.read_data),
    .i_nack_seen (o_out.nack_seen)
);

`default_nettype wire
